FILE: hdl/mbrtu_pkg.sv
package mbrtu_pkg;

   localparam int unsigned FRAME_LEN = 8;
   localparam int unsigned CRC_SPAN  = 6;
   localparam int unsigned COUNT_W   = $clog2(FRAME_LEN);

   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam logic [15:0] CRC_LSB_MASK  = 16'h0001;
   localparam logic [7:0]  SLAVE_RESET   = 8'h01;

   // Header bytes of one frame, byte 0 first on the wire.
   typedef logic [CRC_SPAN-1:0][7:0] span_type;

   typedef struct packed {
      span_type    bytes;
      logic [15:0] crc;
   } cell_data_type;

   typedef logic [FRAME_LEN-1:0][7:0] frame_type;

   // Fold one byte into a CRC-16/MODBUS running value, LSB first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_prev,
                                            input logic [7:0]  data);
      logic [15:0] crc_acc;
      crc_acc = crc_prev ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if ((crc_acc & CRC_LSB_MASK) != 16'h0000) begin
            crc_acc = (crc_acc >> 1) ^ CRC_POLY;
         end else begin
            crc_acc = crc_acc >> 1;
         end
      end
      return crc_acc;
   endfunction

endpackage

FILE: hdl/mbrtu_if.sv
interface mbrtu_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  function_code;
   logic [15:0] register_address;
   logic [15:0] register_value;

   modport source (output valid, output function_code, output register_address,
                   output register_value, input ready);
   modport sink   (input valid, input function_code, input register_address,
                   input register_value, output ready);
endinterface

interface mbrtu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last_byte;

   modport source (output valid, output frame_byte, output last_byte, input ready);
   modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface mbrtu_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] slave_address;

   modport source (output valid, output slave_address, input ready);
   modport sink   (input valid, input slave_address, output ready);
endinterface

FILE: hdl/modbus_rtu_frame_builder.sv
// Channel  Role  Payload                                         Accept
// req_chan sink  function_code, register_address, register_value valid && ready
// rsp_chan src   frame_byte, last_byte                            valid && ready
// csr_chan sink  slave_address                                    valid && ready
//
// Each request yields eight bytes, one per cycle while rsp_chan.ready is high; the next
// frame loads into the output register as the last byte of the current one is taken.
// An accepted request passes through six registered CRC cells into the frame register.
// Reset clears all valid bits and the byte counter; slave_address returns to 1.
// A low rsp_chan.ready holds the current byte; the cells then fill and req_chan.ready drops.
module modbus_rtu_frame_builder (
   input  logic              clock,
   input  logic              reset,
   mbrtu_req_if.sink         req_chan,
   mbrtu_rsp_if.source       rsp_chan,
   mbrtu_csr_if.sink         csr_chan
);

   localparam int unsigned NCELL = mbrtu_pkg::CRC_SPAN;

   logic [7:0] slave_address_ff;
   logic [7:0] slave_address_in;

   logic                     cell_valid [NCELL+1];
   logic                     cell_ready [NCELL+1];
   mbrtu_pkg::cell_data_type cell_data  [NCELL+1];

   // Config write: always taken; user must keep the block idle when it happens (unchecked).
   assign csr_chan.ready = 1'b1;

   always_comb begin
      slave_address_in = slave_address_ff;
      if (csr_chan.valid) begin
         slave_address_in = csr_chan.slave_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= mbrtu_pkg::SLAVE_RESET;
      end else begin
         slave_address_ff <= slave_address_in;
      end
   end

   // Head of the chain: build the six header bytes, seed the CRC.
   assign cell_valid[0]     = req_chan.valid;
   assign req_chan.ready    = cell_ready[0];
   assign cell_data[0].crc  = mbrtu_pkg::CRC_INIT;
   assign cell_data[0].bytes = {req_chan.register_value[7:0],
                                req_chan.register_value[15:8],
                                req_chan.register_address[7:0],
                                req_chan.register_address[15:8],
                                req_chan.function_code,
                                slave_address_ff};

   // Each cell folds one header byte and rotates it to the back, so after
   // all six the bytes are back in wire order.
   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      mbrtu_crc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (cell_valid[k]),
         .up_ready   (cell_ready[k]),
         .up_data    (cell_data[k]),
         .down_valid (cell_valid[k+1]),
         .down_ready (cell_ready[k+1]),
         .down_data  (cell_data[k+1])
      );
   end

   mbrtu_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (cell_valid[NCELL]),
      .in_ready   (cell_ready[NCELL]),
      .in_data    (cell_data[NCELL]),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .frame_byte (rsp_chan.frame_byte),
      .last_byte  (rsp_chan.last_byte)
   );

endmodule

FILE: hdl/mbrtu_crc_cell.sv
// One CRC step: fold the front header byte, rotate it to the back.
module mbrtu_crc_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   up_valid,
   output logic                   up_ready,
   input  mbrtu_pkg::cell_data_type up_data,
   output logic                   down_valid,
   input  logic                   down_ready,
   output mbrtu_pkg::cell_data_type down_data
);

   logic                     valid_ff;
   logic                     valid_in;
   mbrtu_pkg::cell_data_type data_ff;
   mbrtu_pkg::cell_data_type data_in;
   logic                     load;

   assign up_ready = !valid_ff || down_ready;
   assign load     = up_valid && up_ready;

   always_comb begin
      data_in.crc   = mbrtu_pkg::crc_byte(up_data.crc, up_data.bytes[0]);
      data_in.bytes = {up_data.bytes[0], up_data.bytes[mbrtu_pkg::CRC_SPAN-1:1]};
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (down_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = data_ff;

endmodule

FILE: hdl/mbrtu_serializer.sv
// Frame register: load header plus CRC, send one byte per accepted cycle.
module mbrtu_serializer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  mbrtu_pkg::cell_data_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [7:0]             frame_byte,
   output logic                   last_byte
);

   localparam logic [mbrtu_pkg::COUNT_W-1:0] LAST_COUNT =
      mbrtu_pkg::COUNT_W'(mbrtu_pkg::FRAME_LEN - 1);

   mbrtu_pkg::frame_type             frame_ff;
   mbrtu_pkg::frame_type             frame_in;
   logic [mbrtu_pkg::COUNT_W-1:0]    count_ff;
   logic [mbrtu_pkg::COUNT_W-1:0]    count_in;
   logic                             busy_ff;
   logic                             busy_in;
   logic                             load;
   logic                             send;

   assign send     = busy_ff && out_ready;
   assign last_byte = (count_ff == LAST_COUNT);
   assign in_ready = !busy_ff || (out_ready && last_byte);
   assign load     = in_valid && in_ready;

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      if (load) begin
         busy_in  = 1'b1;
         count_in = '0;
      end else if (send) begin
         busy_in  = !last_byte;
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      frame_in = frame_ff;
      if (load) begin
         // CRC goes low byte first, after the header.
         frame_in = {in_data.crc[15:8], in_data.crc[7:0], in_data.bytes};
      end else if (send) begin
         frame_in = {8'h00, frame_ff[mbrtu_pkg::FRAME_LEN-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   assign out_valid  = busy_ff;
   assign frame_byte = frame_ff[0];

   a_load_starts_frame: assert property (@(posedge clock) disable iff (reset)
      load |=> (busy_ff && count_ff == '0))
      else $error("load did not start a frame at byte zero");

   a_midframe_stays_busy: assert property (@(posedge clock) disable iff (reset)
      (send && !last_byte) |=> busy_ff)
      else $error("frame dropped before its last byte");

   a_count_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> busy_ff)
      else $error("byte counter advanced while idle");

   a_ready_when_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> in_ready)
      else $error("idle serializer refused a frame");

endmodule

FILE: sim/tb_modbus_rtu_frame_builder.sv
`timescale 1ns / 1ps

module tb_modbus_rtu_frame_builder;

   localparam int CLK_HALF       = 5;
   localparam int RESET_CYCLES   = 7;
   localparam int LONG_HOLD      = 80;    // receiver hold-off, long enough to back up the input
   localparam int WATCHDOG_LIMIT = 1000;  // cycles without any handshake before giving up
   localparam int DRAIN_CYCLES   = 16;    // extra wait after every expected byte has come back
   localparam int SEGMENTS       = 9;
   localparam int SEG_REQUESTS   = 40;
   localparam int NUM_DIRECTED   = 18;

   // Modbus function codes used by the directed table and the random mix.
   localparam logic [7:0] FC_NONE           = 8'h00;
   localparam logic [7:0] FC_READ_COILS     = 8'h01;
   localparam logic [7:0] FC_READ_DISCRETE  = 8'h02;
   localparam logic [7:0] FC_READ_HOLDING   = 8'h03;
   localparam logic [7:0] FC_READ_INPUT     = 8'h04;
   localparam logic [7:0] FC_WRITE_COIL     = 8'h05;
   localparam logic [7:0] FC_WRITE_REG      = 8'h06;
   localparam logic [7:0] FC_WRITE_COILS    = 8'h0F;
   localparam logic [7:0] FC_WRITE_REGS     = 8'h10;
   localparam logic [7:0] FC_EXCEPTION_FLAG = 8'h80;
   localparam logic [7:0] FC_ALL_ONES       = 8'hFF;

   // Slave addresses: broadcast, highest unicast, all ones.
   localparam logic [7:0] SLAVE_BROADCAST   = 8'h00;
   localparam logic [7:0] SLAVE_MAX_UNICAST = 8'hF7;
   localparam logic [7:0] SLAVE_ALL_ONES    = 8'hFF;

   typedef struct packed {
      logic [7:0] octet;
      logic       last;
   } rtu_byte_type;

   // CRC typed in by hand for a request, or none (then the predictor supplies it).
   typedef struct packed {
      logic        known;
      logic [15:0] crc;
   } listed_crc_type;

   typedef struct packed {
      logic [7:0]  slave;
      logic [7:0]  fc;
      logic [15:0] reg_addr;
      logic [15:0] reg_val;
      logic        known;
      logic [15:0] crc;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   mbrtu_req_if req_bus ();
   mbrtu_rsp_if rsp_bus ();
   mbrtu_csr_if csr_bus ();

   modbus_rtu_frame_builder uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #CLK_HALF clock = ~clock;

   rtu_byte_type   frame_bytes_due [$];  // wire bytes still owed by the block, oldest first
   listed_crc_type listed_crc_q [$];     // one entry per offered request, popped on accept
   logic [7:0]     model_slave;          // predictor copy of the slave address register
   int             mismatches = 0;

   bit req_idle_on  = 1'b1;
   bit rsp_idle_on  = 1'b1;
   bit hold_pending = 1'b0;

   // CRC-16/MODBUS over the six header bytes, byte 0 in the top bits.
   function automatic logic [15:0] rtu_crc(input logic [47:0] header);
      logic [15:0] acc;
      acc = mbrtu_pkg::CRC_INIT;
      for (int i = 5; i >= 0; i--) begin
         acc = acc ^ {8'h00, header[i*8 +: 8]};
         for (int b = 0; b < 8; b++) begin
            acc = acc[0] ? ((acc >> 1) ^ mbrtu_pkg::CRC_POLY) : (acc >> 1);
         end
      end
      return acc;
   endfunction

   // Scoreboard: check returned bytes, track the register, predict each accepted request.
   always @(posedge clock) begin : scoreboard
      rtu_byte_type   due;
      rtu_byte_type   nxt;
      listed_crc_type listed;
      logic [47:0]    header;
      logic [15:0]    crc;
      logic [63:0]    wire_bytes;
      if (reset) begin
         model_slave = mbrtu_pkg::SLAVE_RESET;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (frame_bytes_due.size() == 0) begin
               $error("frame_byte: expected nothing, actual %h", rsp_bus.frame_byte);
               mismatches++;
            end else begin
               due = frame_bytes_due.pop_front();
               if (rsp_bus.frame_byte !== due.octet) begin
                  $error("frame_byte: expected %h, actual %h", due.octet, rsp_bus.frame_byte);
                  mismatches++;
               end
               if (rsp_bus.last_byte !== due.last) begin
                  $error("last_byte: expected %b, actual %b", due.last, rsp_bus.last_byte);
                  mismatches++;
               end
            end
         end
         if (csr_bus.valid && csr_bus.ready) begin
            model_slave = csr_bus.slave_address;
         end
         if (req_bus.valid && req_bus.ready) begin
            listed = listed_crc_q.pop_front();
            header = {model_slave, req_bus.function_code,
                      req_bus.register_address, req_bus.register_value};
            crc = listed.known ? listed.crc : rtu_crc(header);
            // CRC goes out low byte first; only the eighth byte carries last.
            wire_bytes = {header, crc[7:0], crc[15:8]};
            for (int k = 0; k < 8; k++) begin
               nxt.octet = wire_bytes[63 - 8*k -: 8];
               nxt.last  = (k == 7);
               frame_bytes_due.push_back(nxt);
            end
         end
      end
   end

   // Receiver: random stall bursts, a long hold-off on request, none when idling is off.
   initial begin : receiver
      rsp_bus.ready <= 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Watchdog: end the run if no channel moves for too long.
   always @(posedge clock) begin : watchdog
      int quiet;
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet == WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Offer one request and hold it until accepted; maybe leave a short gap after.
   task automatic offer_request(input logic [7:0] fc, input logic [15:0] ra,
                                input logic [15:0] rv, input logic known,
                                input logic [15:0] crc);
      listed_crc_type listed;
      listed.known = known;
      listed.crc   = crc;
      listed_crc_q.push_back(listed);
      req_bus.valid            <= 1'b1;
      req_bus.function_code    <= fc;
      req_bus.register_address <= ra;
      req_bus.register_value   <= rv;
      do @(posedge clock); while (!req_bus.ready);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every expected byte has come back.
   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (frame_bytes_due.size() != 0) @(posedge clock);
   endtask

   // Write the slave address with the block idle.
   task automatic program_slave(input logic [7:0] addr);
      hold_until_drained();
      csr_bus.valid         <= 1'b1;
      csr_bus.slave_address <= addr;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin : stimulus
      stim_row_type directed_rows [0:NUM_DIRECTED-1];
      stim_row_type row;
      logic [7:0]   cur_slave;
      logic [7:0]   fc;
      logic [15:0]  ra;
      logic [15:0]  rv;

      // Rows with a typed CRC are the textbook read-holding-registers frames.
      directed_rows = '{
         '{8'h01, FC_READ_HOLDING, 16'h0000, 16'h000A, 1'b1, 16'hCDC5},
         '{8'h01, FC_READ_HOLDING, 16'h0000, 16'h0001, 1'b1, 16'h0A84},
         '{8'h01, FC_NONE,         16'h0000, 16'h0000, 1'b0, 16'h0000},
         '{8'h01, FC_ALL_ONES,     16'hFFFF, 16'hFFFF, 1'b0, 16'h0000},
         '{8'h01, FC_READ_COILS,   16'h0013, 16'h0025, 1'b0, 16'h0000},
         '{8'h01, FC_READ_DISCRETE, 16'h00C4, 16'h0016, 1'b0, 16'h0000},
         '{8'h01, FC_READ_INPUT,   16'h0008, 16'h0001, 1'b0, 16'h0000},
         '{8'h01, FC_WRITE_COIL,   16'h00AC, 16'hFF00, 1'b0, 16'h0000},
         '{8'h01, FC_WRITE_REG,    16'h0001, 16'h0003, 1'b0, 16'h0000},
         '{8'h01, FC_WRITE_COILS,  16'h0013, 16'h000A, 1'b0, 16'h0000},
         '{8'h01, FC_WRITE_REGS,   16'h0001, 16'h0002, 1'b0, 16'h0000},
         '{8'h01, FC_EXCEPTION_FLAG | FC_READ_HOLDING, 16'h8000, 16'h7FFF, 1'b0, 16'h0000},
         '{SLAVE_BROADCAST, FC_READ_HOLDING, 16'hAAAA, 16'h5555, 1'b0, 16'h0000},
         '{SLAVE_BROADCAST, FC_ALL_ONES,     16'h0000, 16'hFFFF, 1'b0, 16'h0000},
         '{SLAVE_ALL_ONES,  FC_NONE,         16'hFFFF, 16'h0000, 1'b0, 16'h0000},
         '{SLAVE_ALL_ONES,  FC_EXCEPTION_FLAG | FC_WRITE_REGS, 16'h5555, 16'hAAAA, 1'b0,
           16'h0000},
         '{SLAVE_MAX_UNICAST, FC_WRITE_REG,  16'h00FF, 16'hFF00, 1'b0, 16'h0000},
         '{SLAVE_MAX_UNICAST, FC_READ_INPUT, 16'h7FFF, 16'h8000, 1'b0, 16'h0000}
      };

      reset                    <= 1'b1;
      req_bus.valid            <= 1'b0;
      req_bus.function_code    <= FC_NONE;
      req_bus.register_address <= 16'h0000;
      req_bus.register_value   <= 16'h0000;
      csr_bus.valid            <= 1'b0;
      csr_bus.slave_address    <= mbrtu_pkg::SLAVE_RESET;
      cur_slave = mbrtu_pkg::SLAVE_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed table: program the address only when a row asks for a new one.
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         row = directed_rows[i];
         if (row.slave != cur_slave) begin
            program_slave(row.slave);
            cur_slave = row.slave;
         end
         offer_request(row.fc, row.reg_addr, row.reg_val, row.known, row.crc);
      end

      // Random segments, each under its own address and idling mode.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            2:       cur_slave = SLAVE_BROADCAST;
            5:       cur_slave = SLAVE_ALL_ONES;
            7:       cur_slave = mbrtu_pkg::SLAVE_RESET;
            default: cur_slave = 8'($urandom_range(0, 255));
         endcase
         program_slave(cur_slave);
         // Segment 3 runs without idling; the last segment too, and segment 4 without request gaps.
         req_idle_on = !(seg == 3 || seg == SEGMENTS - 1 || seg == 4);
         rsp_idle_on = !(seg == 3 || seg == SEGMENTS - 1);
         // Segment 4: hold off the receiver while requests keep coming back to back.
         if (seg == 4) begin
            hold_pending = 1'b1;
         end
         for (int n = 0; n < SEG_REQUESTS; n++) begin
            // Segment 6: pause mid-way until the block has delivered everything.
            if (seg == 6 && n == SEG_REQUESTS / 2) begin
               hold_until_drained();
            end
            fc = 8'($urandom_range(0, 255));
            ra = 16'($urandom_range(0, 65535));
            rv = 16'($urandom_range(0, 65535));
            case ($urandom_range(0, 9))
               0: ra = 16'h0000;
               1: ra = 16'hFFFF;
               2: rv = 16'h0000;
               3: rv = 16'hFFFF;
               4: fc = FC_READ_HOLDING;
               5: fc = FC_WRITE_REG;
               6: fc = FC_ALL_ONES;
               default: ;
            endcase
            offer_request(fc, ra, rv, 1'b0, 16'h0000);
         end
      end

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
